/* hdl/wld_pkg.sv */
// Shared types, codes and sizes for the work line dispatcher.
// Used by wld_line_ram, wld_owner_tbl and work_line_dispatcher; no dependencies.
package wld_pkg;

  // Sizing
  localparam int MAX_LINES    = 1024;
  localparam int MAX_NODES    = 16;
  localparam int NODE_ID_BITS = 16;

  // Fixed field widths
  localparam int OP_W   = 2;
  localparam int ID_W   = 16;
  localparam int RLEN_W = 16;
  localparam int ST_W   = 3;
  localparam int LC_W   = 11;
  localparam int RW_W   = 13;
  localparam int CFG_DW = 13;

  // Derived sizes
  localparam int LINE_W = $clog2(MAX_LINES);
  localparam int CNT_W  = LINE_W + 1;
  localparam int NODE_W = (NODE_ID_BITS < ID_W) ? NODE_ID_BITS : ID_W;
  localparam int SLOT_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int LANE_W = (MAX_LINES >= 16) ? 4 : 1;
  localparam int LANES  = 1 << LANE_W;
  localparam int ROWS   = (MAX_LINES + LANES - 1) / LANES;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ROW_W  = 2 * LANES;

  // Register reset values
  localparam logic [LC_W-1:0] LC_RESET = LC_W'(1024);
  localparam logic [RW_W-1:0] RW_RESET = RW_W'(1024);

  typedef enum logic [1:0] {
    LS_UNPROC = 2'd0,
    LS_PROC   = 2'd1,
    LS_DONE   = 2'd2
  } lstate_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_UNKNOWN  = 3'd1,
    ST_NOT_PROC = 3'd2,
    ST_SIZE     = 3'd3,
    ST_NO_LINE  = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef enum logic [OP_W-1:0] {
    OP_REQUEST = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_RESULT  = 2'd2
  } op_t;

  typedef enum logic {
    CFG_LINE_COUNT = 1'b0,
    CFG_ROW_WIDTH  = 1'b1
  } cfg_idx_t;

  // Owner table lookup result
  typedef struct packed {
    logic              done;
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic [LINE_W-1:0] hit_line;
    logic              free_found;
    logic [SLOT_W-1:0] free_slot;
  } own_res_t;

  // Owner table update
  typedef struct packed {
    logic              set_en;
    logic              clr_en;
    logic [SLOT_W-1:0] slot;
    logic [NODE_W-1:0] node;
    logic [LINE_W-1:0] line;
  } own_wr_t;

endpackage

/* hdl/wld_line_ram.sv */
// Line state memory: ROWS rows of LANES two-bit line states.
// One write port, one read port with registered read data. Uses wld_pkg.
module wld_line_ram (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [wld_pkg::ROW_AW-1:0] wr_addr,
  input  logic [wld_pkg::ROW_W-1:0]  wr_data,
  input  logic                       rd_en,
  input  logic [wld_pkg::ROW_AW-1:0] rd_addr,
  output logic [wld_pkg::ROW_W-1:0]  rd_data
);

  logic [wld_pkg::ROW_W-1:0] mem_r [wld_pkg::ROWS];
  logic [wld_pkg::ROW_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/wld_owner_tbl.sv */
// Owner table: node to line entries with valid bits and a one-entry-per-cycle
// lookup that finds the node's entry and the first free entry. Uses wld_pkg.
module wld_owner_tbl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       lk_start,
  input  logic [wld_pkg::NODE_W-1:0] lk_key,
  input  wld_pkg::own_wr_t           wr,
  output wld_pkg::own_res_t          res
);

  logic [wld_pkg::MAX_NODES-1:0] valid_r;
  logic [wld_pkg::NODE_W-1:0]    node_r [wld_pkg::MAX_NODES];
  logic [wld_pkg::LINE_W-1:0]    line_r [wld_pkg::MAX_NODES];
  logic                          busy_r;
  logic [wld_pkg::SLOT_W:0]      cnt_r;
  wld_pkg::own_res_t             res_r;
  logic [wld_pkg::SLOT_W-1:0]    idx;
  logic                          match;

  assign idx   = cnt_r[wld_pkg::SLOT_W-1:0];
  assign match = valid_r[idx] && (node_r[idx] == lk_key);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      busy_r   <= 1'b0;
      res_r.done <= 1'b0;
    end else begin
      if (lk_start) begin
        busy_r           <= 1'b1;
        cnt_r            <= '0;
        res_r.hit        <= 1'b0;
        res_r.free_found <= 1'b0;
        res_r.done       <= 1'b0;
      end else if (busy_r) begin
        if (match) begin
          // stop at the first matching entry
          res_r.hit      <= 1'b1;
          res_r.hit_slot <= idx;
          res_r.hit_line <= line_r[idx];
          busy_r         <= 1'b0;
          res_r.done     <= 1'b1;
        end else begin
          if (!valid_r[idx] && !res_r.free_found) begin
            res_r.free_found <= 1'b1;
            res_r.free_slot  <= idx;
          end
          if (cnt_r == (wld_pkg::SLOT_W + 1)'(wld_pkg::MAX_NODES - 1)) begin
            busy_r     <= 1'b0;
            res_r.done <= 1'b1;
          end else begin
            res_r.done <= 1'b0;
          end
          cnt_r <= cnt_r + 1'b1;
        end
      end else begin
        res_r.done <= 1'b0;
      end
      if (wr.set_en) begin
        valid_r[wr.slot] <= 1'b1;
      end
      if (wr.clr_en) begin
        valid_r[wr.slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.set_en) begin
      node_r[wr.slot] <= wr.node;
      line_r[wr.slot] <= wr.line;
    end
  end

  assign res = res_r;

endmodule

/* hdl/work_line_dispatcher.sv */
// Work line dispatcher: hands out work lines to worker nodes and tracks them.
// One item at a time. Throughput: set by the row-at-a-time scan of the line
// state memory and the entry-at-a-time owner lookup. Reset: synchronous,
// active low; afterwards a clearing pass over all ROWS rows zeroes the line
// states, input not ready.
module work_line_dispatcher (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [wld_pkg::OP_W-1:0]   in_op,
  input  logic [wld_pkg::ID_W-1:0]   in_node_id,
  input  logic [wld_pkg::RLEN_W-1:0] in_result_length,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_line_valid,
  output logic [wld_pkg::LINE_W-1:0] out_line_index,
  output logic [wld_pkg::ST_W-1:0]   out_status,
  output logic                       out_all_done,
  // configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [wld_pkg::CFG_DW-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_CLEAR,  // zero the line state memory after reset
    S_IDLE,   // wait for an input transfer
    S_SCAN,   // walk line state rows
    S_LOOK,   // owner table lookup in progress
    S_RD,     // read the row of the node's line
    S_RMW,    // update the node's line
    S_EMIT    // hand the result to the output register
  } state_t;

  state_t                      state_r;

  // configuration
  logic [wld_pkg::LC_W-1:0]    line_count_r;
  logic [wld_pkg::RW_W-1:0]    row_width_r;

  // item under work
  logic [wld_pkg::OP_W-1:0]    op_r;
  logic [wld_pkg::NODE_W-1:0]  key_r;
  logic [wld_pkg::RLEN_W-1:0]  rlen_r;
  logic [wld_pkg::LINE_W-1:0]  line_r;
  logic [wld_pkg::SLOT_W-1:0]  slot_r;
  logic [wld_pkg::ROW_W-1:0]   row_data_r;

  // scan engine
  logic [wld_pkg::ROW_AW:0]    scan_addr_r;
  logic [wld_pkg::ROW_AW-1:0]  rd_row_r;
  logic                        rd_pend_r;
  logic                        find_r;
  logic                        notdone_r;
  logic                        lk_start_r;

  // pending result
  logic                        res_valid_r;
  logic [wld_pkg::LINE_W-1:0]  res_index_r;
  wld_pkg::status_t            res_status_r;
  logic                        res_all_done_r;

  // output register
  logic                        out_valid_r;
  logic                        out_line_valid_r;
  logic [wld_pkg::LINE_W-1:0]  out_line_index_r;
  wld_pkg::status_t            out_status_r;
  logic                        out_all_done_r;

  // combinational
  logic [wld_pkg::CNT_W-1:0]   n_eff;
  logic [wld_pkg::CNT_W-1:0]   rows_used;
  logic                        scan_more;
  logic [wld_pkg::LANES-1:0]   lane_unproc;
  logic [wld_pkg::LANES-1:0]   lane_notdone;
  logic [wld_pkg::LANE_W-1:0]  first_lane;
  logic [wld_pkg::ROW_AW-1:0]  line_row;
  logic [wld_pkg::LANE_W-1:0]  line_lane;
  logic [1:0]                  tgt_state;
  logic [wld_pkg::ROW_W-1:0]   patch_base;
  logic [1:0]                  patch_val;
  logic [wld_pkg::ROW_W-1:0]   patch_row;
  logic                        slot_ok;
  logic [wld_pkg::RLEN_W-1:0]  expect_len;

  logic                        ram_wr_en;
  logic [wld_pkg::ROW_AW-1:0]  ram_wr_addr;
  logic [wld_pkg::ROW_W-1:0]   ram_wr_data;
  logic                        ram_rd_en;
  logic [wld_pkg::ROW_AW-1:0]  ram_rd_addr;
  logic [wld_pkg::ROW_W-1:0]   ram_rd_data;

  wld_pkg::own_wr_t            own_wr;
  wld_pkg::own_res_t           own_res;

  wld_line_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  wld_owner_tbl u_owner (
    .clk      (clk),
    .rst_n    (rst_n),
    .lk_start (lk_start_r),
    .lk_key   (key_r),
    .wr       (own_wr),
    .res      (own_res)
  );

  // Config port: always ready; the user must write only while idle, unchecked.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r <= wld_pkg::LC_RESET;
      row_width_r  <= wld_pkg::RW_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        wld_pkg::CFG_LINE_COUNT: line_count_r <= cfg_data[wld_pkg::LC_W-1:0];
        wld_pkg::CFG_ROW_WIDTH:  row_width_r  <= cfg_data[wld_pkg::RW_W-1:0];
        default: ;
      endcase
    end
  end

  // Lines in use are clamped to the memory size; rows to scan round up.
  assign n_eff = (32'(line_count_r) > 32'(wld_pkg::MAX_LINES)) ?
                 wld_pkg::CNT_W'(wld_pkg::MAX_LINES) : wld_pkg::CNT_W'(line_count_r);
  assign rows_used = (n_eff + wld_pkg::CNT_W'(wld_pkg::LANES - 1)) >> wld_pkg::LANE_W;
  assign scan_more = (32'(scan_addr_r) < 32'(rows_used));

  // Classify the lanes of the row that just came back from memory.
  always_comb begin
    lane_unproc  = '0;
    lane_notdone = '0;
    for (int k = 0; k < wld_pkg::LANES; k++) begin
      if (32'({rd_row_r, wld_pkg::LANE_W'(k)}) < 32'(n_eff)) begin
        lane_unproc[k]  = (ram_rd_data[2*k +: 2] == wld_pkg::LS_UNPROC);
        lane_notdone[k] = (ram_rd_data[2*k +: 2] != wld_pkg::LS_DONE);
      end
    end
  end

  // Lowest unprocessed lane wins.
  always_comb begin
    first_lane = '0;
    for (int k = wld_pkg::LANES - 1; k >= 0; k--) begin
      if (lane_unproc[k]) begin
        first_lane = wld_pkg::LANE_W'(k);
      end
    end
  end

  assign line_row   = wld_pkg::ROW_AW'(line_r >> wld_pkg::LANE_W);
  assign line_lane  = line_r[wld_pkg::LANE_W-1:0];
  assign tgt_state  = ram_rd_data[2*line_lane +: 2];
  assign slot_ok    = own_res.hit || own_res.free_found;
  assign expect_len = wld_pkg::RLEN_W'({row_width_r, 2'b00});

  // Replace one lane of a row.
  always_comb begin
    patch_row = patch_base;
    patch_row[2*line_lane +: 2] = patch_val;
  end

  // Memory and owner table control.
  always_comb begin
    ram_wr_en     = 1'b0;
    ram_wr_addr   = line_row;
    ram_wr_data   = patch_row;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = line_row;
    patch_base    = row_data_r;
    patch_val     = wld_pkg::LS_PROC;
    own_wr.set_en = 1'b0;
    own_wr.clr_en = 1'b0;
    own_wr.slot   = slot_r;
    own_wr.node   = key_r;
    own_wr.line   = line_r;
    case (state_r)
      S_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = scan_addr_r[wld_pkg::ROW_AW-1:0];
        ram_wr_data = '0;
      end
      S_SCAN: begin
        ram_rd_en   = scan_more;
        ram_rd_addr = scan_addr_r[wld_pkg::ROW_AW-1:0];
      end
      S_LOOK: begin
        // request: mark the found line processing and record the owner
        if (own_res.done && op_r == wld_pkg::OP_REQUEST && slot_ok) begin
          ram_wr_en     = 1'b1;
          own_wr.set_en = 1'b1;
          own_wr.slot   = own_res.hit ? own_res.hit_slot : own_res.free_slot;
        end
      end
      S_RD: begin
        ram_rd_en = 1'b1;
      end
      S_RMW: begin
        patch_base = ram_rd_data;
        patch_val  = (op_r == wld_pkg::OP_TIMEOUT) ? wld_pkg::LS_UNPROC : wld_pkg::LS_DONE;
        ram_wr_en  = (tgt_state == wld_pkg::LS_PROC);
        // a timeout forgets the node whatever the line state
        own_wr.clr_en = (op_r == wld_pkg::OP_TIMEOUT);
      end
      default: ;
    endcase
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      scan_addr_r <= '0;
      rd_pend_r   <= 1'b0;
      lk_start_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the output once taken, unless a new result is loaded now
      if (out_ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          scan_addr_r <= scan_addr_r + 1'b1;
          if (scan_addr_r[wld_pkg::ROW_AW-1:0] == wld_pkg::ROW_AW'(wld_pkg::ROWS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r           <= in_op;
            key_r          <= in_node_id[wld_pkg::NODE_W-1:0];
            rlen_r         <= in_result_length;
            res_valid_r    <= 1'b0;
            res_index_r    <= '0;
            res_status_r   <= wld_pkg::ST_OK;
            res_all_done_r <= 1'b0;
            scan_addr_r    <= '0;
            rd_pend_r      <= 1'b0;
            notdone_r      <= 1'b0;
            find_r         <= (in_op == wld_pkg::OP_REQUEST);
            case (in_op)
              wld_pkg::OP_REQUEST: begin
                state_r <= S_SCAN;
              end
              wld_pkg::OP_TIMEOUT, wld_pkg::OP_RESULT: begin
                lk_start_r <= 1'b1;
                state_r    <= S_LOOK;
              end
              default: begin
                // unused op: only the completion check runs
                state_r <= S_SCAN;
              end
            endcase
          end
        end
        S_SCAN: begin
          rd_pend_r <= scan_more;
          rd_row_r  <= scan_addr_r[wld_pkg::ROW_AW-1:0];
          if (scan_more) begin
            scan_addr_r <= scan_addr_r + 1'b1;
          end
          if (rd_pend_r && find_r && (|lane_unproc)) begin
            line_r     <= wld_pkg::LINE_W'({rd_row_r, first_lane});
            row_data_r <= ram_rd_data;
            lk_start_r <= 1'b1;
            state_r    <= S_LOOK;
          end else if (rd_pend_r && !find_r && (|lane_notdone)) begin
            res_all_done_r <= 1'b0;
            state_r        <= S_EMIT;
          end else begin
            if (rd_pend_r) begin
              notdone_r <= notdone_r | (|lane_notdone);
            end
            if (!rd_pend_r && !scan_more) begin
              // every row in use seen
              if (find_r) begin
                res_status_r   <= wld_pkg::ST_NO_LINE;
                res_all_done_r <= !notdone_r;
              end else begin
                res_all_done_r <= 1'b1;
              end
              state_r <= S_EMIT;
            end
          end
        end
        S_LOOK: begin
          // the lookup start is a single-cycle pulse
          lk_start_r <= 1'b0;
          if (own_res.done) begin
            if (op_r == wld_pkg::OP_REQUEST) begin
              // an unprocessed line exists, so not all done either way
              res_all_done_r <= 1'b0;
              if (slot_ok) begin
                res_valid_r <= 1'b1;
                res_index_r <= line_r;
              end else begin
                res_status_r <= wld_pkg::ST_FULL;
              end
              state_r <= S_EMIT;
            end else if (own_res.hit) begin
              line_r  <= own_res.hit_line;
              slot_r  <= own_res.hit_slot;
              state_r <= S_RD;
            end else begin
              res_status_r <= wld_pkg::ST_UNKNOWN;
              scan_addr_r  <= '0;
              rd_pend_r    <= 1'b0;
              state_r      <= S_SCAN;
            end
          end
        end
        S_RD: begin
          state_r <= S_RMW;
        end
        S_RMW: begin
          if (tgt_state != wld_pkg::LS_PROC) begin
            res_status_r <= wld_pkg::ST_NOT_PROC;
          end else if (op_r == wld_pkg::OP_RESULT && rlen_r != expect_len) begin
            // line is still marked done
            res_status_r <= wld_pkg::ST_SIZE;
          end
          scan_addr_r <= '0;
          rd_pend_r   <= 1'b0;
          state_r     <= S_SCAN;
        end
        S_EMIT: begin
          // hold until the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r      <= 1'b1;
            out_line_valid_r <= res_valid_r;
            out_line_index_r <= res_index_r;
            out_status_r     <= res_status_r;
            out_all_done_r   <= res_all_done_r;
            state_r          <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_line_valid = out_line_valid_r;
  assign out_line_index = out_line_index_r;
  assign out_status     = out_status_r;
  assign out_all_done   = out_all_done_r;

endmodule
